// ----- design/ntc_pkg.sv -----
// shared types, constants and the thermistor code table for the ntc lookup block
package ntc_pkg;

    // field widths of the sample and result channels
    localparam int SampleW = 12;
    localparam int TempW   = 16;

    // default for the top level sample width parameter
    localparam int SampleBitsDefault = 12;

    // table geometry: 200 C down to -40 C in 5 C steps
    localparam int TablePoints = 49;
    localparam int TableTopC   = 200;
    localparam int TempStep    = 5;
    localparam int LoBits      = $clog2(TablePoints);

    // saturation codes
    localparam logic signed [TempW-1:0] TempHot  = 16'sh7FFF;
    localparam logic signed [TempW-1:0] TempCold = 16'sh8000;

    // divider widths: offset times step, and the quotient 0..TempStep
    localparam int QBits    = $clog2(TempStep + 1);
    localparam int ProdBits = SampleW + QBits;

    // fifo between front and back
    localparam int QueueDepth = 2;

    // ascending adc codes, entry i belongs to TableTopC - i * TempStep
    localparam logic [SampleW-1:0] NtcCode [TablePoints] = '{
        12'd61,   12'd67,   12'd73,   12'd80,   12'd88,
        12'd97,   12'd107,  12'd119,  12'd131,  12'd146,
        12'd162,  12'd181,  12'd202,  12'd226,  12'd253,
        12'd284,  12'd319,  12'd360,  12'd406,  12'd460,
        12'd520,  12'd590,  12'd669,  12'd759,  12'd861,
        12'd976,  12'd1105, 12'd1249, 12'd1407, 12'd1580,
        12'd1765, 12'd1962, 12'd2166, 12'd2374, 12'd2582,
        12'd2785, 12'd2979, 12'd3160, 12'd3324, 12'd3469,
        12'd3596, 12'd3703, 12'd3792, 12'd3865, 12'd3922,
        12'd3968, 12'd4002, 12'd4029, 12'd4048
    };

    // sample class decided in the front
    typedef enum logic [1:0] {
        KIND_HOT,
        KIND_COLD,
        KIND_SPAN
    } t_kind;

    // classified item carried through the fifo
    typedef struct packed {
        t_kind              kind;
        logic [LoBits-1:0]  lo;
        logic [SampleW-1:0] sample;
    } t_front_item;

    // fifo status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // temperature of table entry idx
    function automatic logic signed [TempW-1:0] ntc_temp(input logic [LoBits-1:0] idx);
        return TempW'(TableTopC - TempStep * int'(idx));
    endfunction

endpackage

// ----- design/ntc_if.sv -----
// valid/ready stream interfaces for the sample and temperature channels
interface ntc_sample_if;
    import ntc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SampleW-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface ntc_temp_if;
    import ntc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [TempW-1:0] temperature_c;

    modport source (output valid, output temperature_c, input ready);
    modport sink   (input valid, input temperature_c, output ready);
endinterface

// ----- design/ntc_front.sv -----
// front stage: masks the sample, compares it against the table and classifies it
module ntc_front
    import ntc_pkg::*;
#(
    parameter int SAMPLE_BITS = SampleBitsDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntc_sample_if.sink    i_sample,
    input  t_q_status     i_q_status,
    output logic          o_push,
    output t_front_item   o_item
);

    localparam logic [SampleW-1:0] SampleMask = (SAMPLE_BITS >= SampleW) ?
        {SampleW{1'b1}} : SampleW'((1 << SAMPLE_BITS) - 1);

    logic               r_valid;
    logic               n_valid;
    t_front_item        r_item;
    t_front_item        n_item;
    logic               accept;
    logic [SampleW-1:0] sample;
    logic [TablePoints-1:0] lt;

    // accept while the stage is empty or drains into the fifo this cycle
    assign o_push         = r_valid && !i_q_status.full;
    assign i_sample.ready = !r_valid || !i_q_status.full;
    assign accept         = i_sample.valid && i_sample.ready;
    assign o_item         = r_item;

    // table compares: lt is a thermometer since codes ascend
    always_comb begin
        sample = i_sample.raw_sample & SampleMask;
        for (int i = 0; i < TablePoints; i++) begin
            lt[i] = NtcCode[i] < sample;
        end
    end

    // classify and locate the lower entry of the bracketing pair
    always_comb begin
        n_item.sample = sample;
        n_item.lo     = '0;
        for (int i = 0; i < TablePoints - 1; i++) begin
            if (lt[i] && !lt[i+1]) begin
                n_item.lo = n_item.lo | LoBits'(i);
            end
        end
        priority if (!lt[0]) begin
            n_item.kind = KIND_HOT;
        end else if (lt[TablePoints-1]) begin
            n_item.kind = KIND_COLD;
        end else begin
            n_item.kind = KIND_SPAN;
        end
    end

    // stage valid
    always_comb begin
        n_valid = accept || (r_valid && !o_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- design/ntc_queue.sv -----
// small register fifo between the front and back stages
module ntc_queue
    import ntc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_front_item i_item,
    input  logic        i_pop,
    output t_front_item o_item,
    output t_q_status   o_status
);

    localparam int PtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CountBits = $clog2(QueueDepth + 1);

    t_front_item          r_mem [QueueDepth];
    logic [PtrBits-1:0]   r_wr;
    logic [PtrBits-1:0]   n_wr;
    logic [PtrBits-1:0]   r_rd;
    logic [PtrBits-1:0]   n_rd;
    logic [CountBits-1:0] r_count;
    logic [CountBits-1:0] n_count;

    assign o_status.full  = r_count == CountBits'(QueueDepth);
    assign o_status.empty = r_count == '0;
    assign o_item         = r_mem[r_rd];

    // pointer and count update with explicit wrap
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrBits'(QueueDepth - 1)) ? '0 : r_wr + PtrBits'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrBits'(QueueDepth - 1)) ? '0 : r_rd + PtrBits'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CountBits'(1);
            2'b01:   n_count = r_count - CountBits'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // the front never pushes into a full fifo, the back never pops an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full || i_pop))
        else $error("fifo push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("fifo pop while empty");

endmodule

// ----- design/ntc_back.sv -----
// back stages: table lookup, interpolation by a short divider and the output register
module ntc_back
    import ntc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_status   i_q_status,
    input  t_front_item i_item,
    output logic        o_pop,
    ntc_temp_if.source  o_temp
);

    typedef struct packed {
        t_kind                   kind;
        logic [SampleW-1:0]      offset;
        logic [SampleW-1:0]      span;
        logic signed [TempW-1:0] base;
    } t_s1;

    logic                    r_s1_valid;
    t_s1                     r_s1;
    t_s1                     n_s1;
    logic                    r_out_valid;
    logic signed [TempW-1:0] r_out_temp;
    logic signed [TempW-1:0] n_out_temp;
    logic                    adv_out;
    logic                    adv_s1;
    logic [ProdBits-1:0]     num;
    logic [QBits-1:0]        quot;
    logic [LoBits-1:0]       hi_idx;

    // pipeline advance, output register parts the stages from the receiver
    assign adv_out = !r_out_valid || o_temp.ready;
    assign adv_s1  = !r_s1_valid || adv_out;
    assign o_pop   = !i_q_status.empty && adv_s1;

    assign o_temp.valid         = r_out_valid;
    assign o_temp.temperature_c = r_out_temp;

    // lookup of the bracketing pair
    always_comb begin
        hi_idx      = i_item.lo + LoBits'(1);
        n_s1.kind   = i_item.kind;
        n_s1.offset = i_item.sample - NtcCode[i_item.lo];
        n_s1.span   = NtcCode[hi_idx] - NtcCode[i_item.lo];
        n_s1.base   = ntc_temp(i_item.lo);
    end

    // quotient of offset * step over span, known to lie in 0..TempStep
    always_comb begin
        num  = ProdBits'(r_s1.offset) * ProdBits'(TempStep);
        quot = '0;
        for (int k = 1; k <= TempStep; k++) begin
            if (ProdBits'(r_s1.span) * ProdBits'(k) <= num) begin
                quot = quot + QBits'(1);
            end
        end
    end

    // result select
    always_comb begin
        unique case (r_s1.kind)
            KIND_HOT:  n_out_temp = TempHot;
            KIND_COLD: n_out_temp = TempCold;
            KIND_SPAN: n_out_temp = r_s1.base - $signed({{(TempW-QBits){1'b0}}, quot});
            default:   n_out_temp = TempCold;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= o_pop;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv_s1 && o_pop) begin
            r_s1 <= n_s1;
        end
        if (adv_out && r_s1_valid) begin
            r_out_temp <= n_out_temp;
        end
    end

    // an interpolated sample lies strictly above the lower code and at most at the upper
    a_offset_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.kind == KIND_SPAN) |->
            (r_s1.offset != '0 && r_s1.offset <= r_s1.span))
        else $error("interpolation offset outside its span");
    a_result_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.kind == KIND_SPAN && adv_out) |=>
            (r_out_temp <= 16'sd200 && r_out_temp >= -16'sd40))
        else $error("interpolated temperature outside the table range");

endmodule

// ----- design/ntc_table_interpolate.sv -----
// top level of the thermistor table lookup with linear interpolation
//
// i_sample carries one 12-bit thermistor divider code per transfer; only the
// low SAMPLE_BITS bits take part. o_temp returns one signed 16-bit
// temperature in whole degrees Celsius for every sample, in order:
// 32767 above the table top, -32768 below the table bottom, otherwise the
// value interpolated between the two bracketing entries, truncated.
// From the input transfer to o_temp.valid a sample passes the compare
// register of the front, which loads at the transfer edge, then the fifo
// entry, the lookup register and the output register, in that order.
// Throughput is one sample per cycle while o_temp.ready is high, set by the
// front compare register and the back lookup and output registers.
// When the receiver holds o_temp.ready low the result stays in the output
// register; the back stalls, the two-entry fifo fills, and only then does
// i_sample.ready drop. Reset empties the front, the fifo and the back; no
// table is loaded, it is fixed logic.
module ntc_table_interpolate
    import ntc_pkg::*;
#(
    parameter int SAMPLE_BITS = SampleBitsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ntc_sample_if.sink i_sample,
    ntc_temp_if.source o_temp
);

    t_q_status   q_status;
    t_front_item push_item;
    t_front_item pop_item;
    logic        push;
    logic        pop;

    // classification
    ntc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_sample),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    // decoupling fifo
    ntc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (q_status)
    );

    // lookup, interpolation and output
    ntc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_temp     (o_temp)
    );

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the thermistor table lookup with linear interpolation
module tb;
    import ntc_pkg::*;

    // thermistor divider codes, ascending; point i stands for 200 - 5 * i degrees
    localparam int CurvePoints = 49;
    localparam int CurveTopC   = 200;
    localparam int CurveStepC  = 5;
    localparam int CurveCode [CurvePoints] = '{
          61,   67,   73,   80,   88,   97,  107,  119,  131,  146,
         162,  181,  202,  226,  253,  284,  319,  360,  406,  460,
         520,  590,  669,  759,  861,  976, 1105, 1249, 1407, 1580,
        1765, 1962, 2166, 2374, 2582, 2785, 2979, 3160, 3324, 3469,
        3596, 3703, 3792, 3865, 3922, 3968, 4002, 4029, 4048
    };

    // saturation values of the result
    localparam logic signed [TempW-1:0] SatHot  = 16'sh7FFF;
    localparam logic signed [TempW-1:0] SatCold = 16'sh8000;

    localparam int RandomSamples = 600;
    localparam int HoldAfter     = 200;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 20;
    localparam int CycleLimit    = 400000;

    // one temperature awaited on the output, with the sample that caused it
    typedef struct {
        logic [SampleW-1:0]      sample;
        logic signed [TempW-1:0] temp;
    } t_due_temp;

    logic i_clk;
    logic i_rst_n;

    ntc_sample_if sample_bus ();
    ntc_temp_if   temp_bus ();

    logic [SampleW-1:0] samples_to_send [$];
    t_due_temp          temps_due [$];
    int                 n_accepted;
    int                 n_errors;
    int                 cycle_count;

    ntc_table_interpolate DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_bus),
        .o_temp   (temp_bus)
    );

    // temperature in degrees for an adc code, saturating outside the curve
    function automatic logic signed [TempW-1:0] celsius_from_code(
        input logic [SampleW-1:0] code
    );
        int idx;
        int lower;
        int span;
        int offset;
        int step;
        idx = 0;
        while (idx < CurvePoints && CurveCode[idx] < int'(code)) idx++;
        if (idx == 0) return SatHot;
        if (idx >= CurvePoints) return SatCold;
        lower  = CurveCode[idx-1];
        offset = lower - int'(code);
        span   = CurveCode[idx] - lower;
        // offset is never positive here, so the product is not negative
        step   = (span > 0) ? (offset * (-CurveStepC)) / span : 0;
        return TempW'(CurveTopC - CurveStepC * (idx - 1) - step);
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sample driver: one transfer per accepted offer, gaps between them
    int send_gap;
    int n_sent;
    always @(posedge i_clk) begin
        logic               next_valid;
        logic [SampleW-1:0] next_sample;
        next_valid  = sample_bus.valid;
        next_sample = sample_bus.raw_sample;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            send_gap   = 0;
        end else if (!sample_bus.valid || sample_bus.ready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (samples_to_send.size() > 0) begin
                next_valid  = 1'b1;
                next_sample = samples_to_send.pop_front();
                n_sent++;
                // every so often a run of back-to-back samples
                send_gap = (n_sent % 128 < 32) ? 0 : idle_length();
            end
        end
        sample_bus.valid      <= next_valid;
        sample_bus.raw_sample <= next_sample;
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    int  rx_stall;
    int  rx_hold;
    int  rx_cycles;
    bit  rx_hold_done;
    always @(posedge i_clk) begin
        rx_cycles++;
        if (!i_rst_n) begin
            temp_bus.ready <= 1'b0;
        end else if (!rx_hold_done && n_accepted >= HoldAfter) begin
            rx_hold_done = 1'b1;
            rx_hold      = HoldCycles;
            temp_bus.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            temp_bus.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            temp_bus.ready <= 1'b0;
        end else begin
            temp_bus.ready <= 1'b1;
            if (temp_bus.valid && temp_bus.ready && rx_cycles % 512 >= 128)
                rx_stall = idle_length();
        end
    end

    // monitor: check output transfers, then queue the prediction for input transfers
    always @(posedge i_clk) begin
        t_due_temp due;
        if (i_rst_n) begin
            if (temp_bus.valid && temp_bus.ready) begin
                if (temps_due.size() == 0) begin
                    $display("%0t: unexpected temperature transfer, got %0d",
                             $time, temp_bus.temperature_c);
                    n_errors++;
                end else begin
                    due = temps_due.pop_front();
                    if (temp_bus.temperature_c !== due.temp) begin
                        $display("%0t: temperature_c for sample %0d: expected %0d, got %0d",
                                 $time, due.sample, due.temp, temp_bus.temperature_c);
                        n_errors++;
                    end
                end
            end
            if (sample_bus.valid && sample_bus.ready) begin
                due.sample = sample_bus.raw_sample;
                due.temp   = celsius_from_code(sample_bus.raw_sample);
                temps_due.push_back(due);
                n_accepted <= n_accepted + 1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int r;
        int k;
        int v;
        i_rst_n               = 1'b0;
        sample_bus.valid      = 1'b0;
        sample_bus.raw_sample = '0;
        temp_bus.ready        = 1'b0;
        n_accepted            = 0;
        n_errors              = 0;
        cycle_count           = 0;

        // extremes, both saturation edges, exact table codes and their neighbors
        samples_to_send = '{
            12'd0,    12'd4095, 12'd1,    12'd4094, 12'd60,   12'd61,
            12'd62,   12'd66,   12'd67,   12'd68,   12'd1580, 12'd1581,
            12'd2000, 12'd2047, 12'd2048, 12'd3595, 12'd3596, 12'd4047,
            12'd4048, 12'd4049, 12'hAAA,  12'h555
        };

        // random: mostly near table codes, some at the ends, the rest uniform
        for (int i = 0; i < RandomSamples; i++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                k = $urandom_range(CurvePoints - 1);
                v = CurveCode[k] + int'($urandom_range(6)) - 3;
            end else if (r < 65) begin
                v = $urandom_range(1) ? $urandom_range(4040, 4095) : $urandom_range(70);
            end else begin
                v = $urandom_range(4095);
            end
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            samples_to_send.push_back(SampleW'(v));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every sample to go in and every temperature to come out
        do @(negedge i_clk);
        while (samples_to_send.size() > 0 || sample_bus.valid || temps_due.size() > 0);
        repeat (DrainCycles) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/ntc_pkg.sv
design/ntc_if.sv
design/ntc_front.sv
design/ntc_queue.sv
design/ntc_back.sv
design/ntc_table_interpolate.sv
verif/tb.sv
